[rtl/core/indexed_integer_list_macros.svh]
// Assertion macros for the indexed integer list checker.
// No dependencies; included by the checker file.
`ifndef INDEXED_INTEGER_LIST_MACROS_SVH
`define INDEXED_INTEGER_LIST_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define IIL_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");

// When trig holds, res must hold at the next clock edge.
`define IIL_ASSERT_NEXT(lbl, clk, rst_n, trig, res) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
    else $error("%m: check failed");

`endif

[rtl/core/iil_pkg.sv]
// Shared types and codes for the indexed integer list.
// No dependencies.
`default_nettype none

package iil_pkg;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;
  localparam logic [1:0] OpGet    = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  localparam logic signed [31:0] MinValue = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        position;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         entry_count;
  } out_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic        ins;    // shift up from where, write new value at where
    logic        rem;    // shift down from where upwards
    logic [15:0] where;  // target index, also the read index
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/core/indexed_integer_list.sv]
// Indexed integer list: a chain of cells with append, insert, remove and get.
// Results pass through the registered first level of the OR tree that reads the addressed
// cell, then the output register; one transaction per cycle while the result side does
// not stall. All cells shift in parallel in the acceptance cycle.
// Reset clears the count and the handshake state at once; cell contents are not cleared.
// Depends on iil_pkg, iil_cell.
`default_nettype none

module indexed_integer_list #(
  parameter int CAPACITY = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  iil_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output iil_pkg::out_t out_data_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int GW   = 32;
  localparam int NG   = (CAPACITY + GW - 1) / GW;

  logic [CntW-1:0] count_q, count_d;
  logic            busy_q;
  logic            out_valid_q;
  iil_pkg::out_t   out_data_q;

  // Pending result of the transaction in flight
  logic            p_get_q;
  logic [1:0]      p_status_q, p_status_d;
  logic [CntW-1:0] p_count_q;

  logic               accept, out_free, load_out;
  logic               full, pos_in;
  iil_pkg::cell_cmd_t cmd;

  logic signed [31:0] value_w [CAPACITY];
  logic signed [31:0] sel_w   [CAPACITY];
  logic signed [31:0] grp_d   [NG];
  logic signed [31:0] grp_q   [NG];
  logic signed [31:0] rd_w;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = busy_q && out_free;
  assign in_stall_o = busy_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign full   = (count_q == CntW'(CAPACITY));
  assign pos_in = (in_data_i.position < 16'(count_q));

  // Decode the operation into a cell command, status and new count
  always_comb begin
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    cmd.where  = in_data_i.position;
    p_status_d = iil_pkg::StOk;
    count_d    = count_q;
    case (in_data_i.opcode)
      iil_pkg::OpAppend, iil_pkg::OpInsert: begin
        if (full) begin
          p_status_d = iil_pkg::StFull;
        end else begin
          cmd.ins = accept;
          count_d = count_q + CntW'(1);
          if (in_data_i.opcode == iil_pkg::OpAppend || !pos_in) begin
            cmd.where = 16'(count_q);
          end
        end
      end
      iil_pkg::OpRemove: begin
        if (pos_in) begin
          cmd.rem = accept;
          count_d = count_q - CntW'(1);
        end else begin
          p_status_d = iil_pkg::StRange;
        end
      end
      iil_pkg::OpGet: begin
        if (!pos_in) begin
          p_status_d = iil_pkg::StRange;
        end
      end
      default: begin
        p_status_d = iil_pkg::StOk;
      end
    endcase
  end

  // Chain of cells; the ends feed back their own value
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [31:0] lower, upper;
    if (k == 0) begin : g_lo_end
      assign lower = value_w[k];
    end else begin : g_lo
      assign lower = value_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_hi_end
      assign upper = value_w[k];
    end else begin : g_hi
      assign upper = value_w[k+1];
    end
    iil_cell #(.IDX(k)) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .new_value_i (in_data_i.item_value),
      .lower_i     (lower),
      .upper_i     (upper),
      .value_o     (value_w[k]),
      .sel_o       (sel_w[k])
    );
  end

  // First level of the read tree, registered per group of cells
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GW; j++) begin
        if (g * GW + j < CAPACITY) begin
          grp_d[g] = grp_d[g] | sel_w[g * GW + j];
        end
      end
    end
  end

  // Second level of the read tree
  always_comb begin
    rd_w = '0;
    for (int g = 0; g < NG; g++) begin
      rd_w = rd_w | grp_q[g];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_get_q    <= (in_data_i.opcode == iil_pkg::OpGet);
      p_status_q <= p_status_d;
      p_count_q  <= count_d;
      for (int g = 0; g < NG; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
    if (load_out) begin
      out_data_q.status      <= p_status_q;
      out_data_q.entry_count <= 7'(p_count_q);
      if (!p_get_q) begin
        out_data_q.read_value <= '0;
      end else if (p_status_q == iil_pkg::StOk) begin
        out_data_q.read_value <= rd_w;
      end else begin
        out_data_q.read_value <= iil_pkg::MinValue;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[rtl/core/iil_cell.sv]
// One storage cell of the list chain.
// Depends on iil_pkg.
`default_nettype none

module iil_cell #(
  parameter int IDX = 0
) (
  input  wire                     clk_i,
  input  iil_pkg::cell_cmd_t      cmd_i,
  input  wire logic signed [31:0] new_value_i,
  input  wire logic signed [31:0] lower_i,
  input  wire logic signed [31:0] upper_i,
  output logic signed [31:0]      value_o,
  output logic signed [31:0]      sel_o
);

  logic signed [31:0] value_q, value_d;
  logic               hit, above;

  assign hit   = (cmd_i.where == 16'(IDX));
  assign above = (16'(IDX) > cmd_i.where);

  // Next value: take neighbour on a shift, new value at the insert point
  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (hit) begin
        value_d = new_value_i;
      end else if (above) begin
        value_d = lower_i;
      end
    end else if (cmd_i.rem) begin
      if (hit || above) begin
        value_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // Read leaf: only the addressed cell contributes
  assign sel_o   = hit ? value_q : '0;

endmodule

`default_nettype wire

[rtl/core/iil_checker.sv]
// Port-level checks for the indexed integer list, bound to the top level.
// Depends on iil_pkg and indexed_integer_list_macros.svh.
`default_nettype none

`include "indexed_integer_list_macros.svh"

module iil_checker #(
  parameter int CAPACITY = 64
) (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_stall_i,
  input iil_pkg::in_t  in_data_i,
  input wire           out_valid_i,
  input wire           out_stall_i,
  input iil_pkg::out_t out_data_i
);

  logic [1:0]         st;
  logic signed [31:0] rv;
  logic [6:0]         cnt;
  logic               in_seen, in_acc, quiet, out_held;
  logic               st_legal, full_ok, range_ok;

  assign st      = out_data_i.status;
  assign rv      = out_data_i.read_value;
  assign cnt     = out_data_i.entry_count;
  assign in_seen = in_valid_i && (in_data_i.opcode == iil_pkg::OpGet || !in_stall_i);
  assign in_acc  = in_valid_i && !in_stall_i;
  assign quiet   = !out_valid_i && !in_seen;
  assign out_held = out_valid_i && out_stall_i;

  assign st_legal = st == iil_pkg::StOk || st == iil_pkg::StRange || st == iil_pkg::StFull;
  assign full_ok  = st != iil_pkg::StFull || (cnt == 7'(CAPACITY) && rv == 32'sd0);
  assign range_ok = st != iil_pkg::StRange || rv == 32'sd0 || rv == iil_pkg::MinValue;

  // A stalled result holds
  `IIL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_i && $stable(out_data_i))

  // Status is one of the three codes
  `IIL_ASSERT_ALWAYS(a_status_code, clk_i, rst_ni, !out_valid_i || st_legal)

  // A full rejection reports the capacity as the count and reads nothing
  `IIL_ASSERT_ALWAYS(a_full_count, clk_i, rst_ni, !out_valid_i || full_ok)

  // An out-of-range result reads either zero (remove) or the minimum value (get)
  `IIL_ASSERT_ALWAYS(a_range_value, clk_i, rst_ni, !out_valid_i || range_ok)

  // Nothing sits idle: a result cannot appear without an earlier transaction
  `IIL_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, quiet && !$past(in_acc), !out_valid_i)

endmodule

bind indexed_integer_list iil_checker #(.CAPACITY(CAPACITY)) u_iil_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

[tb/sv/indexed_integer_list_test.sv]
// Self-checking testbench for indexed_integer_list: random and directed list operations,
// predicted by a mirror of the list and checked transaction by transaction.
// Depends on iil_pkg and the indexed_integer_list RTL.
module indexed_integer_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef iil_pkg::in_t  in_t;
  typedef iil_pkg::out_t out_t;

  localparam logic [1:0]         OpAppend = iil_pkg::OpAppend;
  localparam logic [1:0]         OpInsert = iil_pkg::OpInsert;
  localparam logic [1:0]         OpRemove = iil_pkg::OpRemove;
  localparam logic [1:0]         OpGet    = iil_pkg::OpGet;
  localparam logic [1:0]         StOk     = iil_pkg::StOk;
  localparam logic [1:0]         StRange  = iil_pkg::StRange;
  localparam logic [1:0]         StFull   = iil_pkg::StFull;
  localparam logic signed [31:0] MinValue = iil_pkg::MinValue;

  localparam int          Capacity   = 64;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned RandomOps  = 2000;

  typedef enum {PhaseFill, PhaseMixed, PhaseDrain} phase_e;

  typedef struct {
    in_t         op;
    int unsigned gap;
    bit          drain;
  } pending_op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_q = 1'b0;
  in_t  in_data_q = '0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_q = 1'b0;
  out_t out_data_o;

  pending_op_t        pending_ops[$];
  out_t               expected_results[$];
  logic signed [31:0] mirror_cells[$];

  int unsigned plan_count    = 0;
  int unsigned items_planned = 0;
  bit          tx_calm       = 1'b0;
  bit          rx_calm       = 1'b0;
  int unsigned gap_done      = 0;
  int unsigned stall_left    = 0;
  int unsigned rx_cycles     = 0;
  int unsigned results_seen  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned fail_cnt      = 0;

  indexed_integer_list #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .out_data_o  (out_data_o)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one operation to the mirror and return the result it should produce
  function automatic out_t apply_list_op(in_t op);
    out_t res;
    res = '0;
    res.status = StOk;
    case (op.opcode)
      OpAppend, OpInsert: begin
        // full check comes before any index check
        if (mirror_cells.size() >= Capacity) begin
          res.status = StFull;
        end else if (op.opcode == OpInsert && op.position < mirror_cells.size()) begin
          mirror_cells.insert(op.position, op.item_value);
        end else begin
          mirror_cells.push_back(op.item_value);
        end
      end
      OpRemove: begin
        if (op.position < mirror_cells.size()) begin
          mirror_cells.delete(op.position);
        end else begin
          res.status = StRange;
        end
      end
      default: begin
        if (op.position < mirror_cells.size()) begin
          res.read_value = mirror_cells[op.position];
        end else begin
          res.read_value = MinValue;
          res.status = StRange;
        end
      end
    endcase
    res.entry_count = 7'(mirror_cells.size());
    return res;
  endfunction

  // Sender gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Queue one transaction and track the count it leaves behind
  function automatic void plan_op(logic [1:0] opc, logic [15:0] pos,
                                  logic signed [31:0] val, bit drain);
    pending_op_t p;
    p.op.opcode     = opc;
    p.op.position   = pos;
    p.op.item_value = val;
    p.gap           = pick_gap();
    p.drain         = drain;
    pending_ops.push_back(p);
    case (opc)
      OpAppend, OpInsert: if (plan_count < Capacity) plan_count++;
      OpRemove:           if (pos < plan_count) plan_count--;
      default: ;
    endcase
    items_planned++;
    if (items_planned % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endfunction

  // Index: mostly within or just past the list, sometimes anywhere
  function automatic logic [15:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, plan_count));
    if (r < 80 && plan_count != 0) return 16'(plan_count - 1);
    if (r < 90) return 16'($urandom_range(0, 65535));
    return 16'(plan_count + $urandom_range(0, 3));
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh7fff_ffff;
      1:       return MinValue;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Operation mix per phase
  function automatic void plan_random(phase_e ph, bit drain);
    int unsigned r;
    logic [1:0]  opc;
    r = $urandom_range(0, 99);
    case (ph)
      PhaseFill:  opc = (r < 45) ? OpAppend : (r < 80) ? OpInsert : (r < 90) ? OpGet : OpRemove;
      PhaseDrain: opc = (r < 60) ? OpRemove : (r < 85) ? OpGet : (r < 95) ? OpInsert : OpAppend;
      default:    opc = (r < 25) ? OpAppend : (r < 50) ? OpInsert : (r < 75) ? OpRemove : OpGet;
    endcase
    plan_op(opc, pick_position(), pick_value(), drain);
  endfunction

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned target;
    int unsigned n;
    bit          pause;

    // directed: empty list, extremes, insert past the end, out-of-range remove and get
    plan_op(OpGet,    16'd0,     32'sd0, 1'b0);
    plan_op(OpGet,    16'hffff,  32'sd0, 1'b0);
    plan_op(OpRemove, 16'd0,     32'sd0, 1'b0);
    plan_op(OpRemove, 16'hffff,  32'sd0, 1'b0);
    plan_op(OpAppend, 16'hffff,  32'sh7fff_ffff, 1'b0);
    plan_op(OpAppend, 16'd0,     MinValue, 1'b0);
    plan_op(OpAppend, 16'd0,     32'sd0, 1'b0);
    plan_op(OpAppend, 16'd0,     -32'sd1, 1'b0);
    plan_op(OpInsert, 16'd0,     32'sh5555_5555, 1'b0);
    plan_op(OpInsert, 16'd2,     32'shaaaa_aaaa, 1'b0);
    plan_op(OpInsert, 16'hffff,  32'sd123, 1'b0);
    plan_op(OpInsert, 16'd7,     -32'sd7, 1'b0);
    plan_op(OpGet,    16'd0,     32'sd0, 1'b0);
    plan_op(OpGet,    16'd3,     32'sd0, 1'b0);
    plan_op(OpGet,    16'd7,     32'sd0, 1'b0);
    plan_op(OpGet,    16'd8,     32'sd0, 1'b0);
    plan_op(OpGet,    16'hffff,  32'sd0, 1'b0);
    plan_op(OpRemove, 16'd2,     32'sd0, 1'b0);
    plan_op(OpRemove, 16'd6,     32'sd0, 1'b0);
    plan_op(OpRemove, 16'h8000,  32'sd0, 1'b0);
    plan_op(OpRemove, 16'd0,     32'sd0, 1'b0);
    plan_op(OpGet,    16'd0,     32'sd0, 1'b0);

    // random: rounds of fill to full, mixed, drain to empty, mixed
    target = pending_ops.size() + RandomOps;
    pause  = 1'b1;
    while (pending_ops.size() < target) begin
      while (plan_count < Capacity) begin
        plan_random(PhaseFill, pause);
        pause = 1'b0;
      end
      // push against the full list
      n = $urandom_range(3, 8);
      repeat (n) plan_op(($urandom_range(0, 1) != 0) ? OpAppend : OpInsert,
                         pick_position(), pick_value(), 1'b0);
      pause = ($urandom_range(0, 1) != 0);
      n = $urandom_range(60, 120);
      repeat (n) begin
        plan_random(PhaseMixed, pause);
        pause = 1'b0;
      end
      pause = ($urandom_range(0, 1) != 0);
      while (plan_count != 0) begin
        plan_random(PhaseDrain, pause);
        pause = 1'b0;
      end
      // poke the empty list
      n = $urandom_range(2, 5);
      repeat (n) plan_op(($urandom_range(0, 1) != 0) ? OpRemove : OpGet,
                         pick_position(), pick_value(), 1'b0);
      n = $urandom_range(40, 100);
      repeat (n) plan_random(PhaseMixed, 1'b0);
      pause = ($urandom_range(0, 1) != 0);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid_q || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Driver: offers queued transactions, predicts each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic offer_nxt;
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      gap_done = 0;
    end else begin
      if (in_valid_q && !in_stall_o) begin
        expected_results.push_back(apply_list_op(in_data_q));
      end
      // payload held while stalled
      if (!in_valid_q || !in_stall_o) begin
        offer_nxt = 1'b0;
        if (pending_ops.size() != 0) begin
          if (gap_done < pending_ops[0].gap) begin
            gap_done++;
          end else if (!(pending_ops[0].drain && expected_results.size() != 0)) begin
            in_data_q <= pending_ops[0].op;
            offer_nxt = 1'b1;
            void'(pending_ops.pop_front());
            gap_done = 0;
          end
        end
        in_valid_q <= offer_nxt;
      end
    end
  end

  // Monitor: checks each result transaction and drives the receiver stall
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_t want;
    logic stall_nxt;
    if (!rst_ni) begin
      out_stall_q <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_q) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: %p", out_data_o);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value,
                   out_data_o.read_value);
            fail_cnt++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            fail_cnt++;
          end
          if (out_data_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data_o.entry_count);
            fail_cnt++;
          end
        end
        // long hold-off so the block backs up into its input
        if (results_seen == 400 || results_seen == 1500) stall_left = LongHold;
      end

      rx_cycles++;
      if (rx_cycles % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);

      stall_nxt = 1'b0;
      if (stall_left != 0) begin
        stall_left--;
        stall_nxt = 1'b1;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) :
                                                    $urandom_range(0, 2);
        stall_nxt = 1'b1;
      end
      out_stall_q <= stall_nxt;
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_q && !in_stall_o) || (out_valid_o && !out_stall_q)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $error("no transaction for %0d cycles", IdleLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/iil_pkg.sv
rtl/core/iil_cell.sv
rtl/core/indexed_integer_list.sv
rtl/core/iil_checker.sv
tb/sv/indexed_integer_list_test.sv
